FILE: rtl/rsc_pkg.sv
// Shared types and constants for the row spill cache controller.
// Holds the beat structs, result kinds, mode codes and the controller-to-datapath links.
// Depends on nothing; every other file imports it.
package rsc_pkg;

  localparam int MAX_BLOCK_BYTES = 1024;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_ROW = 4'd1;

  localparam logic [1:0] MODE_ACCESS = 2'd0;
  localparam logic [1:0] MODE_FLUSH  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] KIND_WRITE_BACK = 3'd0;
  localparam logic [2:0] KIND_FILL       = 3'd1;
  localparam logic [2:0] KIND_GRANT      = 3'd2;
  localparam logic [2:0] KIND_REJECT     = 3'd3;
  localparam logic [2:0] KIND_FLUSH_DONE = 3'd4;

  // Current-slot pointer updates.
  localparam logic [2:0] CUR_HOLD   = 3'd0;
  localparam logic [2:0] CUR_HIT    = 3'd1;
  localparam logic [2:0] CUR_VICTIM = 3'd2;
  localparam logic [2:0] CUR_ZERO   = 3'd3;
  localparam logic [2:0] CUR_INC    = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [39:0] region_offset;
    logic [10:0] blk_bytes;
    logic [11:0] blocks_across;
    logic [11:0] blocks_down;
    logic [11:0] block_x;
    logic [11:0] block_y;
    logic        writable;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  slot;
    logic [40:0] mem_address;
    logic [21:0] byte_count;
    logic [21:0] byte_offset;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic [2:0] cur_sel;
    logic       step_cnt;
    logic       write_tag;
    logic       clear_dirty;
    logic       set_dirty;
    logic       clear_all;
    logic       emit;
    logic [2:0] emit_kind;
    logic       emit_last;
  } rsc_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic is_clear;
    logic is_bad;
    logic hit;
    logic all_valid;
    logic cur_wb;
    logic cur_last;
    logic writable;
  } rsc_status_t;

endpackage

FILE: rtl/rsc_datapath.sv
// Datapath of the row spill cache controller: slot tags, replacement counter,
// address and offset arithmetic, and the result register.
// Depends on rsc_pkg; driven by rsc_ctrl through rsc_cmd_t.
module rsc_datapath import rsc_pkg::*; #(
  parameter int SLOT_COUNT    = 4,
  parameter int ADDRESS_WIDTH = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_item,
  input  rsc_cmd_t              cmd,
  output rsc_status_t           st,
  output logic                  out_valid,
  output out_item_t             out_item
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

  logic                     enabled_r;
  logic [21:0]              large_r;
  in_item_t                 in_r;
  logic                     valid_r  [SLOT_COUNT];
  logic [ADDRESS_WIDTH-1:0] region_r [SLOT_COUNT];
  logic [11:0]              row_r    [SLOT_COUNT];
  logic [10:0]              bsize_r  [SLOT_COUNT];
  logic [22:0]              rbytes_r [SLOT_COUNT];
  logic                     dirty_r  [SLOT_COUNT];
  logic [31:0]              cnt_r;
  logic [SLOT_W-1:0]        res_r    [2:SLOT_COUNT];
  logic [SLOT_W-1:0]        cur_r, cur_nxt;
  logic [22:0]              row_bytes_r;
  logic                     hit_r;
  logic [SLOT_W-1:0]        hit_idx_r;
  logic [SLOT_COUNT-1:0]    large_mask_r;
  logic [34:0]              prod_r;
  logic                     out_valid_r;
  out_item_t                out_r, out_nxt;

  logic [47:0]              in_reg48;
  logic [ADDRESS_WIDTH-1:0] region_in;
  logic                     hit_c;
  logic [SLOT_W-1:0]        hit_idx_c;
  logic [SLOT_W-1:0]        inv_idx;
  logic                     all_valid;
  logic                     need_large;
  logic [CNT_W-1:0]         n_large;
  logic                     use_large;
  logic [CNT_W-1:0]         modulus;
  logic [SLOT_W-1:0]        rr;
  logic [SLOT_COUNT-1:0]    cand_mask;
  logic [SLOT_COUNT-1:0]    below_m;
  logic [SLOT_W-1:0]        rr_idx;
  logic [SLOT_W-1:0]        victim;
  logic [ADDRESS_WIDTH-1:0] sel_region;
  logic [47:0]              sel_reg48;
  logic [11:0]              sel_row;
  logic [10:0]              sel_bsize;
  logic [22:0]              sel_rbytes;
  logic [22:0]              offset_full;

  assign in_reg48  = 48'(in_r.region_offset);
  assign region_in = in_reg48[ADDRESS_WIDTH-1:0];

  assign sel_region = region_r[cur_r];
  assign sel_reg48  = 48'(sel_region);
  assign sel_row    = row_r[cur_r];
  assign sel_bsize  = bsize_r[cur_r];
  assign sel_rbytes = rbytes_r[cur_r];

  // Tag compare and lowest invalid slot, both priority to the lowest index.
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    inv_idx   = '0;
    all_valid = 1'b1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (valid_r[i] && region_r[i] == region_in && row_r[i] == in_r.block_y) begin
        hit_c     = 1'b1;
        hit_idx_c = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        all_valid = 1'b0;
        inv_idx   = SLOT_W'(i);
      end
    end
  end

  // Round robin victim: the rr-th candidate, rr being the counter modulo the
  // candidate count, taken from the running residues.
  always_comb begin
    need_large = row_bytes_r >= {1'b0, large_r};
    n_large    = CNT_W'($countones(large_mask_r));
    use_large  = need_large && (n_large >= CNT_W'(2));
    modulus    = use_large ? n_large : CNT_W'(SLOT_COUNT);
    cand_mask  = use_large ? large_mask_r : '1;
    rr         = res_r[SLOT_COUNT];
    for (int k = 2; k <= SLOT_COUNT; k++) begin
      if (modulus == CNT_W'(k)) begin
        rr = res_r[k];
      end
    end
    rr_idx  = '0;
    below_m = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      below_m = cand_mask & ((SLOT_COUNT'(1) << i) - SLOT_COUNT'(1));
      if (cand_mask[i] && CNT_W'($countones(below_m)) == CNT_W'(rr)) begin
        rr_idx = SLOT_W'(i);
      end
    end
    victim = all_valid ? rr_idx : inv_idx;
  end

  always_comb begin
    case (cmd.cur_sel)
      CUR_HOLD:   cur_nxt = cur_r;
      CUR_HIT:    cur_nxt = hit_idx_r;
      CUR_VICTIM: cur_nxt = victim;
      CUR_ZERO:   cur_nxt = '0;
      CUR_INC:    cur_nxt = cur_r + SLOT_W'(1);
      default:    cur_nxt = cur_r;
    endcase
  end

  assign offset_full = 23'(in_r.block_x) * 23'(sel_bsize);

  always_comb begin
    out_nxt      = '0;
    out_nxt.kind = cmd.emit_kind;
    out_nxt.last = cmd.emit_last;
    case (cmd.emit_kind)
      KIND_WRITE_BACK, KIND_FILL: begin
        out_nxt.slot        = 2'(cur_r);
        out_nxt.mem_address = sel_reg48[40:0] + 41'(prod_r);
        out_nxt.byte_count  = sel_rbytes[21:0];
      end
      KIND_GRANT: begin
        out_nxt.slot        = 2'(cur_r);
        out_nxt.byte_offset = offset_full[21:0];
      end
      default: begin
        out_nxt.slot = '0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      large_r   <= 22'(MAX_BLOCK_BYTES);
    end else if (cfg_we) begin
      if (cfg_index == CFG_ENABLED) begin
        enabled_r <= cfg_wdata[0];
      end else if (cfg_index == CFG_LARGE_ROW) begin
        large_r <= cfg_wdata[21:0];
      end
    end
  end

  // Slot state.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        valid_r[i]  <= 1'b0;
        region_r[i] <= '0;
        row_r[i]    <= '0;
        bsize_r[i]  <= '0;
        rbytes_r[i] <= '0;
        dirty_r[i]  <= 1'b0;
      end
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cur_r == SLOT_W'(i)) begin
          if (cmd.write_tag) begin
            valid_r[i]  <= 1'b1;
            region_r[i] <= region_in;
            row_r[i]    <= in_r.block_y;
            bsize_r[i]  <= in_r.blk_bytes;
            rbytes_r[i] <= row_bytes_r;
            dirty_r[i]  <= 1'b0;
          end else if (cmd.clear_dirty) begin
            dirty_r[i] <= 1'b0;
          end else if (cmd.set_dirty) begin
            dirty_r[i] <= 1'b1;
          end
        end
      end
    end
  end

  // Replacement counter with its residues modulo every candidate count.
  // On wrap of the counter all residues restart at zero with it.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      cnt_r <= '0;
      for (int k = 2; k <= SLOT_COUNT; k++) begin
        res_r[k] <= '0;
      end
    end else if (cmd.step_cnt) begin
      cnt_r <= cnt_r + 32'd1;
      for (int k = 2; k <= SLOT_COUNT; k++) begin
        if (cnt_r == '1 || res_r[k] == SLOT_W'(k - 1)) begin
          res_r[k] <= '0;
        end else begin
          res_r[k] <= res_r[k] + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
    if (cmd.capture) begin
      row_bytes_r <= 23'(in_r.blk_bytes) * 23'(in_r.blocks_across);
      hit_r       <= hit_c;
      hit_idx_r   <= hit_idx_c;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        large_mask_r[i] <= rbytes_r[i] >= {1'b0, large_r};
      end
    end
    prod_r <= 35'(sel_row) * 35'(sel_rbytes);
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign st.is_flush  = (in_r.mode == MODE_FLUSH) || (in_r.mode == MODE_CLEAR);
  assign st.is_clear  = (in_r.mode == MODE_CLEAR);
  assign st.is_bad    = (in_r.mode == MODE_UNUSED) || !enabled_r ||
                        (in_r.blk_bytes == '0) ||
                        (in_r.blk_bytes > 11'(MAX_BLOCK_BYTES)) ||
                        (in_r.blocks_across == '0) || (in_r.blocks_down == '0) ||
                        (in_r.block_x >= in_r.blocks_across) ||
                        (in_r.block_y >= in_r.blocks_down);
  assign st.hit       = hit_r;
  assign st.all_valid = all_valid;
  assign st.cur_wb    = valid_r[cur_r] && dirty_r[cur_r];
  assign st.cur_last  = (cur_r == SLOT_W'(SLOT_COUNT - 1));
  assign st.writable  = in_r.writable;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/rsc_ctrl.sv
// Sequencer of the row spill cache controller: steps one request through
// check, lookup, write back, fill and grant, through a reject, or through a flush sweep.
// Depends on rsc_pkg; drives rsc_datapath through rsc_cmd_t.
module rsc_ctrl import rsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rsc_status_t st,
  output rsc_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_LOOKUP  = 4'd2;
  localparam logic [3:0] S_V_PREP  = 4'd3;
  localparam logic [3:0] S_V_EMIT  = 4'd4;
  localparam logic [3:0] S_F_PREP  = 4'd5;
  localparam logic [3:0] S_F_EMIT  = 4'd6;
  localparam logic [3:0] S_GRANT   = 4'd7;
  localparam logic [3:0] S_REJECT  = 4'd8;
  localparam logic [3:0] S_FL_PREP = 4'd9;
  localparam logic [3:0] S_FL_EMIT = 4'd10;
  localparam logic [3:0] S_FL_DONE = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.cur_sel = CUR_HOLD;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.capture = 1'b1;
        if (st.is_flush) begin
          cmd.cur_sel = CUR_ZERO;
          state_nxt   = S_FL_PREP;
        end else if (st.is_bad) begin
          state_nxt = S_REJECT;
        end else begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (st.hit) begin
          cmd.cur_sel = CUR_HIT;
          state_nxt   = S_GRANT;
        end else begin
          cmd.cur_sel  = CUR_VICTIM;
          cmd.step_cnt = st.all_valid;
          state_nxt    = S_V_PREP;
        end
      end
      S_V_PREP: begin
        state_nxt = S_V_EMIT;
      end
      S_V_EMIT: begin
        cmd.emit      = st.cur_wb;
        cmd.emit_kind = KIND_WRITE_BACK;
        cmd.write_tag = 1'b1;
        state_nxt     = S_F_PREP;
      end
      S_F_PREP: begin
        state_nxt = S_F_EMIT;
      end
      S_F_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_FILL;
        state_nxt     = S_GRANT;
      end
      S_GRANT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_GRANT;
        cmd.emit_last = 1'b1;
        cmd.set_dirty = st.writable;
        state_nxt     = S_IDLE;
      end
      S_REJECT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_REJECT;
        cmd.emit_last = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FL_PREP: begin
        state_nxt = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        cmd.emit        = st.cur_wb;
        cmd.emit_kind   = KIND_WRITE_BACK;
        cmd.clear_dirty = 1'b1;
        if (st.cur_last) begin
          state_nxt = S_FL_DONE;
        end else begin
          cmd.cur_sel = CUR_INC;
          state_nxt   = S_FL_PREP;
        end
      end
      S_FL_DONE: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_FLUSH_DONE;
        cmd.emit_last = 1'b1;
        cmd.clear_all = st.is_clear;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/row_spill_cache_controller.sv
// Row spill cache controller: tag control for a small write-back cache of rows.
// On a hit a request steps through check, lookup and grant; a reject through check
// and reject; a miss adds the write-back and fill steps; a flush sweeps every slot.
// One request at a time: no new request is taken while busy is high.
// Reset (synchronous, rst_n low) empties all slots; results cannot be held off.
module row_spill_cache_controller import rsc_pkg::*; #(
  parameter int SLOT_COUNT    = 4,
  parameter int ADDRESS_WIDTH = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel: a beat is taken when start is high and busy is low.
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  // Result channel: one beat per cycle in which out_valid is high.
  output logic                  out_valid,
  output out_item_t             out_item,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rsc_cmd_t    cmd;
  rsc_status_t st;

  // Registers are plain flops, so a write is always taken at once.
  assign cfg_ready = 1'b1;

  // The sequencer decides what happens in each cycle; the datapath holds all
  // tag state and forms the addresses, byte counts and offsets of each beat.
  rsc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  rsc_datapath #(
    .SLOT_COUNT    (SLOT_COUNT),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/rsc_checker.sv
// Port-level checks for the row spill cache controller, with the bind that
// attaches them to the top level. Depends on rsc_pkg.
module rsc_checker import rsc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // No beat can come out in the cycle right after a request is taken.
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result beat right after accept");

  // The final beat of a request coincides with the block being free again.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy)
    else $error("busy still high with last beat");

  // Rejections and flush completions are always the final beat.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.kind == KIND_REJECT || out_item.kind == KIND_FLUSH_DONE))
      |-> out_item.last)
    else $error("reject or flush done not marked last");

  // A beat while idle can only be the last one of a request.
  a_idle_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !busy) |-> out_item.last)
    else $error("non-final beat while idle");

endmodule

bind row_spill_cache_controller rsc_checker u_rsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

FILE: tb/tb_row_spill_cache_controller.sv
// Self-checking testbench for the row spill cache controller: directed and random
// request beats, a predictor of the tag state and a result scoreboard.
// Depends on rsc_pkg and the row_spill_cache_controller RTL only.
module tb_row_spill_cache_controller;
  import rsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS           = 4;
  localparam int SETTLE_CYCLES   = 16;    // longer than a full flush of four slots
  localparam int WATCHDOG_CYCLES = 1000;  // cycles with no beat on any channel

  // A request beat as queued for the driver. A beat marked drain is held back
  // until every result already owed by the block has come out.
  typedef struct packed {
    logic     drain;
    in_item_t beat;
  } request_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  row_spill_cache_controller #(
    .SLOT_COUNT   (SLOTS),
    .ADDRESS_WIDTH(40)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Request beats waiting to be driven, and the result beats the block owes.
  request_t  request_q[$];
  out_item_t due_beats[$];

  // Shadow copy of the register file and of the tag store.
  logic        cfg_enabled   = 1'b0;
  logic [21:0] cfg_big_bytes = 22'd1024;
  logic        cache_valid[SLOTS];
  logic [39:0] cache_region[SLOTS];
  logic [11:0] cache_row[SLOTS];
  logic [10:0] cache_bsize[SLOTS];
  logic [22:0] cache_row_bytes[SLOTS];
  logic        cache_dirty[SLOTS];
  logic [31:0] replace_count = '0;

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  bit beat_taken     = 1'b0;  // set at the edge that takes a request beat
  bit calm           = 1'b0;  // no sender gaps in the closing part of the run
  int gap_left       = 0;

  // A few region bases, so that random accesses hit each other's rows.
  logic [39:0] region_pool[4] = '{40'h00_0000_0000, 40'hFF_FFFF_FFFF,
                                  40'h00_0040_0000, 40'h80_0000_1000};

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      cache_valid[s]     = 1'b0;
      cache_region[s]    = '0;
      cache_row[s]       = '0;
      cache_bsize[s]     = '0;
      cache_row_bytes[s] = '0;
      cache_dirty[s]     = 1'b0;
    end
  end

  // A request beat made of random bits.
  function automatic in_item_t junk_item();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return in_item_t'(bits[$bits(in_item_t)-1:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic out_item_t make_beat(logic [2:0] kind, int s, logic [40:0] addr,
                                          logic [21:0] count, logic [21:0] offset);
    out_item_t b;
    b.kind        = kind;
    b.slot        = 2'(s);
    b.mem_address = addr;
    b.byte_count  = count;
    b.byte_offset = offset;
    b.last        = 1'b0;
    return b;
  endfunction

  // Backing-store address of the row held in a slot, 41 bits wide.
  function automatic logic [40:0] row_address(int s);
    logic [63:0] sum;
    sum = 64'(cache_region[s]) + 64'(cache_row[s]) * 64'(cache_row_bytes[s]);
    return sum[40:0];
  endfunction

  // A valid dirty slot is written back; either way it ends up clean.
  function automatic void retire_slot(int s);
    if (cache_valid[s] && cache_dirty[s])
      due_beats.push_back(make_beat(KIND_WRITE_BACK, s, row_address(s),
                                    cache_row_bytes[s][21:0], '0));
    cache_dirty[s] = 1'b0;
  endfunction

  // Works out every result beat that one accepted request causes and queues
  // them in order, with last set on the final one.
  function automatic void predict_cache_beats(in_item_t it);
    logic [22:0] need;
    logic [22:0] offset;
    int          hit;
    int          victim;
    int unsigned n_big;
    int          big_slots[SLOTS];
    out_item_t   tail;
    hit    = -1;
    victim = -1;
    n_big  = 0;
    if (it.mode == MODE_FLUSH || it.mode == MODE_CLEAR) begin
      for (int s = 0; s < SLOTS; s++)
        retire_slot(s);
      if (it.mode == MODE_CLEAR) begin
        for (int s = 0; s < SLOTS; s++) begin
          cache_valid[s]     = 1'b0;
          cache_region[s]    = '0;
          cache_row[s]       = '0;
          cache_bsize[s]     = '0;
          cache_row_bytes[s] = '0;
          cache_dirty[s]     = 1'b0;
        end
        replace_count = '0;
      end
      due_beats.push_back(make_beat(KIND_FLUSH_DONE, 0, '0, '0, '0));
    end else if (it.mode == MODE_UNUSED || !cfg_enabled || it.blk_bytes == '0 ||
                 it.blk_bytes > MAX_BLOCK_BYTES || it.blocks_across == '0 ||
                 it.blocks_down == '0 || it.block_x >= it.blocks_across ||
                 it.block_y >= it.blocks_down) begin
      due_beats.push_back(make_beat(KIND_REJECT, 0, '0, '0, '0));
    end else begin
      need = 23'(it.blk_bytes) * 23'(it.blocks_across);
      // A hit needs only region and row to match; the geometry may differ.
      for (int s = SLOTS - 1; s >= 0; s--)
        if (cache_valid[s] && cache_region[s] == it.region_offset &&
            cache_row[s] == it.block_y)
          hit = s;
      if (hit < 0) begin
        // Lowest empty slot first; with all slots full, a big row evicts one
        // of the big rows if there are at least two, else any slot goes.
        for (int s = SLOTS - 1; s >= 0; s--)
          if (!cache_valid[s])
            victim = s;
        if (victim < 0) begin
          if (need >= cfg_big_bytes)
            for (int s = 0; s < SLOTS; s++)
              if (cache_row_bytes[s] >= cfg_big_bytes) begin
                big_slots[n_big] = s;
                n_big++;
              end
          if (n_big >= 2)
            victim = big_slots[replace_count % n_big];
          else
            victim = int'(replace_count % SLOTS);
          replace_count = replace_count + 1;
        end
        retire_slot(victim);
        cache_valid[victim]     = 1'b1;
        cache_region[victim]    = it.region_offset;
        cache_row[victim]       = it.block_y;
        cache_bsize[victim]     = it.blk_bytes;
        cache_row_bytes[victim] = need;
        cache_dirty[victim]     = 1'b0;
        due_beats.push_back(make_beat(KIND_FILL, victim, row_address(victim),
                                      need[21:0], '0));
        hit = victim;
      end
      if (it.writable)
        cache_dirty[hit] = 1'b1;
      // The grant offset always uses the block size stored with the row.
      offset = 23'(it.block_x) * 23'(cache_bsize[hit]);
      due_beats.push_back(make_beat(KIND_GRANT, hit, '0, '0, offset[21:0]));
    end
    tail      = due_beats.pop_back();
    tail.last = 1'b1;
    due_beats.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns mismatch: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Everything is sampled at the rising edge, before the block's own updates
  // of that edge can be seen. Results are checked before the request taken at
  // the same edge is predicted, so the order of expectations stays right.
  always @(posedge clk) begin
    out_item_t want;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid !== 1'b0) begin
        moved = 1'b1;
        if (due_beats.size() == 0) begin
          report_mismatch("result beat with none owed, kind", 64'(out_item.kind), '0);
        end else begin
          want = due_beats.pop_front();
          if (out_item.kind !== want.kind)
            report_mismatch("kind", 64'(out_item.kind), 64'(want.kind));
          if (out_item.slot !== want.slot)
            report_mismatch("slot", 64'(out_item.slot), 64'(want.slot));
          if (out_item.mem_address !== want.mem_address)
            report_mismatch("mem_address", 64'(out_item.mem_address),
                            64'(want.mem_address));
          if (out_item.byte_count !== want.byte_count)
            report_mismatch("byte_count", 64'(out_item.byte_count),
                            64'(want.byte_count));
          if (out_item.byte_offset !== want.byte_offset)
            report_mismatch("byte_offset", 64'(out_item.byte_offset),
                            64'(want.byte_offset));
          if (out_item.last !== want.last)
            report_mismatch("last", 64'(out_item.last), 64'(want.last));
        end
      end
      if (start && busy === 1'b0) begin
        moved      = 1'b1;
        beat_taken = 1'b1;
        predict_cache_beats(in_item);
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        moved = 1'b1;
        if (cfg_index == CFG_ENABLED)
          cfg_enabled = cfg_wdata[0];
        else if (cfg_index == CFG_LARGE_ROW)
          cfg_big_bytes = cfg_wdata;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // The run is stopped if no beat moves on any channel for too long.
  initial begin
    wait (quiet_cycles >= WATCHDOG_CYCLES);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Inputs change at the falling edge. A beat stays on the port until the
  // monitor has seen it taken; between beats the sender may now and then idle,
  // with junk on the payload while start is low.
  always @(negedge clk) begin
    request_t nxt;
    if (!start || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        start   <= 1'b0;
        in_item <= junk_item();
      end else if (request_q.size() == 0 ||
                   (request_q[0].drain && due_beats.size() != 0)) begin
        start <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 3);
        start   <= 1'b0;
        in_item <= junk_item();
      end else begin
        nxt = request_q.pop_front();
        in_item <= nxt.beat;
        start   <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic in_item_t access_item(logic [39:0] region, logic [10:0] bsize,
                                           logic [11:0] across, logic [11:0] down,
                                           logic [11:0] bx, logic [11:0] by, logic wr);
    in_item_t it;
    it.mode          = MODE_ACCESS;
    it.region_offset = region;
    it.blk_bytes     = bsize;
    it.blocks_across = across;
    it.blocks_down   = down;
    it.block_x       = bx;
    it.block_y       = by;
    it.writable      = wr;
    return it;
  endfunction

  // Flush, clear or unused mode: the other fields are don't-care, so they are random.
  function automatic in_item_t mode_item(logic [1:0] mode);
    in_item_t it;
    it      = junk_item();
    it.mode = mode;
    return it;
  endfunction

  // A well-formed access to one of a handful of rows, mostly small rows so that
  // hits are common, with an occasional very wide row or tall region.
  function automatic in_item_t random_access();
    in_item_t it;
    it.mode          = MODE_ACCESS;
    it.region_offset = region_pool[$urandom_range(0, 3)];
    it.block_y       = 12'($urandom_range(0, 5));
    it.blocks_down   = (($urandom_range(0, 15) == 0) ? 12'd4095 :
                        it.block_y + 12'($urandom_range(1, 3)));
    case ($urandom_range(0, 7))
      0:       it.blk_bytes = 11'd1;
      1:       it.blk_bytes = 11'd1024;
      default: it.blk_bytes = 11'($urandom_range(1, 128));
    endcase
    it.blocks_across = (($urandom_range(0, 9) == 0) ? 12'($urandom_range(1, 4095)) :
                        12'($urandom_range(1, 24)));
    it.block_x       = 12'($urandom_range(0, it.blocks_across - 1));
    it.writable      = 1'($urandom);
    return it;
  endfunction

  task automatic push_item(in_item_t it, logic drain);
    request_t r;
    r.drain = drain;
    r.beat  = it;
    request_q.push_back(r);
  endtask

  // Mostly well-formed accesses, some flushes and clears, and a share of
  // fully random beats that mostly get rejected.
  task automatic queue_random(int count, int drain_odds);
    in_item_t it;
    int       pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 76)
        it = random_access();
      else if (pick < 84)
        it = mode_item(MODE_FLUSH);
      else if (pick < 87)
        it = mode_item(MODE_CLEAR);
      else
        it = junk_item();
      push_item(it, drain_odds != 0 && $urandom_range(1, drain_odds) == 1);
    end
  endtask

  // Register writes go through their own valid/ready channel.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until all queued beats are taken and every owed result has come,
  // then lets the block finish any trailing work. The check is made just after
  // the rising edge so that it sees both the driver and the monitor settled.
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (request_q.size() != 0 || start || due_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Straight out of reset the cache is off: accesses are rejected, flushes work.
    push_item(access_item(40'h0, 11'd4, 12'd4, 12'd4, 12'd1, 12'd1, 1'b1), 1'b0);
    push_item(mode_item(MODE_FLUSH), 1'b0);
    push_item(mode_item(MODE_CLEAR), 1'b0);
    push_item(mode_item(MODE_UNUSED), 1'b0);
    settle();

    // Upper data bits set: only bit 0 of the enable register counts.
    write_reg(CFG_ENABLED, 22'h3F_FFFF);
    write_reg(CFG_LARGE_ROW, 22'd1024);

    // Smallest row, then a hit on it that dirties the slot, then a hit on the
    // same row with a different geometry.
    push_item(access_item(40'h0, 11'd1, 12'd1, 12'd1, 12'd0, 12'd0, 1'b0), 1'b0);
    push_item(access_item(40'h0, 11'd1, 12'd1, 12'd1, 12'd0, 12'd0, 1'b1), 1'b0);
    push_item(access_item(40'h0, 11'd1024, 12'd4095, 12'd4095, 12'd4094, 12'd0, 1'b0),
              1'b0);
    // Largest row at the top of storage: the address needs all 41 bits.
    push_item(access_item(40'hFF_FFFF_FFFF, 11'd1024, 12'd4095, 12'd4095, 12'd4094,
                          12'd4094, 1'b1), 1'b0);
    push_item(access_item(40'hFF_FFFF_FFFF, 11'd512, 12'd4, 12'd2, 12'd3, 12'd1, 1'b1),
              1'b0);
    push_item(access_item(40'h00_0040_0000, 11'd8, 12'd2, 12'd4, 12'd1, 12'd3, 1'b0),
              1'b0);
    // All slots full now: a big row evicts among the big rows, writing back
    // a dirty one first; a small row then goes round robin over all slots.
    push_item(access_item(40'h80_0000_1000, 11'd256, 12'd8, 12'd3, 12'd7, 12'd2, 1'b0),
              1'b0);
    push_item(access_item(40'h80_0000_1000, 11'd1, 12'd1, 12'd8, 12'd0, 12'd7, 1'b1),
              1'b0);
    push_item(access_item(40'h80_0000_1000, 11'd64, 12'd20, 12'd8, 12'd19, 12'd5, 1'b1),
              1'b0);
    // The sender waits for the cache to go quiet before this flush.
    push_item(mode_item(MODE_FLUSH), 1'b1);
    push_item(access_item(40'h0, 11'd1024, 12'd4095, 12'd4095, 12'd0, 12'd0, 1'b1), 1'b0);
    push_item(mode_item(MODE_CLEAR), 1'b0);
    push_item(mode_item(MODE_FLUSH), 1'b0);  // nothing left to write back
    push_item(mode_item(MODE_UNUSED), 1'b0);
    // Malformed accesses, each failing at least one of the checks.
    push_item(access_item(40'h0, 11'd0, 12'd4, 12'd4, 12'd0, 12'd0, 1'b1), 1'b0);
    push_item(access_item(40'h0, 11'd1025, 12'd4, 12'd4, 12'd0, 12'd0, 1'b1), 1'b0);
    push_item(access_item(40'h0, 11'd2047, 12'd4, 12'd4, 12'd0, 12'd0, 1'b0), 1'b0);
    push_item(access_item(40'h0, 11'd4, 12'd0, 12'd4, 12'd0, 12'd0, 1'b0), 1'b0);
    push_item(access_item(40'h0, 11'd4, 12'd4, 12'd0, 12'd0, 12'd0, 1'b0), 1'b0);
    push_item(access_item(40'h0, 11'd4, 12'd5, 12'd5, 12'd5, 12'd0, 1'b0), 1'b0);
    push_item(access_item(40'h0, 11'd4, 12'd5, 12'd5, 12'd0, 12'd5, 1'b0), 1'b0);
    push_item(access_item(40'hFF_FFFF_FFFF, 11'd1024, 12'd4095, 12'd4095, 12'd4095,
                          12'd4095, 1'b1), 1'b0);
    settle();

    // Every row counts as big.
    write_reg(CFG_LARGE_ROW, 22'd1);
    queue_random(55, 0);
    settle();

    // Only the very largest row counts as big.
    write_reg(CFG_LARGE_ROW, 22'd4193280);
    queue_random(45, 0);
    settle();

    // Cache switched off again, with junk in the upper data bits.
    write_reg(CFG_ENABLED, 22'h2A_AAAA);
    queue_random(6, 0);
    settle();

    // Mixed big and small rows, with the sender now and then draining first.
    write_reg(CFG_ENABLED, 22'd1);
    write_reg(CFG_LARGE_ROW, 22'd64);
    queue_random(60, 12);
    settle();

    // Closing part at full rate, no sender gaps.
    calm = 1'b1;
    write_reg(CFG_LARGE_ROW, 22'd300);
    queue_random(45, 0);
    settle();

    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
